FILE: sv/md5_hash_engine_core_assert.svh
// ----------------------------------------------------------------------------
// MD5 engine assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MD5_HASH_ENGINE_CORE_ASSERT_SVH
`define MD5_HASH_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define MD5HE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MD5HE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MD5HE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MD5HE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/md5he_pkg.sv
// ----------------------------------------------------------------------------
// MD5 engine package
// States, round constants, shift amounts and helper functions.
// ----------------------------------------------------------------------------
package md5he_pkg;

    localparam logic [31:0] C_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [7:0] C_PAD_BYTE   = 8'h80;
    localparam logic [5:0] C_LAST_ROUND = 6'h3f;
    localparam logic [5:0] C_LEN_POS    = 6'd56;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZBLK,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        NX_IDLE,
        NX_PAD,
        NX_ZBLK,
        NX_OUT
    } t_next;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        logic [3:0] j;
        j = i[3:0];
        case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = {j[1:0], 2'b00} + j + 4'd1;
            2'd2:    g = {j[2:0], 1'b0} + j + 4'd5;
            2'd3:    g = {j[0], 3'b000} - j;
            default: g = j;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

FILE: sv/md5he_if.sv
// ----------------------------------------------------------------------------
// MD5 engine channel interfaces
// Valid/ready channels for message bytes and for digests.
// ----------------------------------------------------------------------------
interface md5he_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output msg_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input msg_byte, input has_byte, input last,
                    output ready);
endinterface

interface md5he_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_lo;
    logic [63:0] digest_hi;

    modport source (output valid, output digest_lo, output digest_hi, input ready);
    modport sink   (input valid, input digest_lo, input digest_hi, output ready);
endinterface

FILE: sv/md5_hash_engine_core.sv
// ----------------------------------------------------------------------------
// Byte-serial MD5 engine: one byte beat per cycle while idle; 64 bytes fill a block.
// A full block then runs 64 rounds of one shared round unit, followed by the chain add.
// A last beat reaches the digest beat via pad, 64 rounds, add and output; a spilled
// length adds a second block, and a beat that fills a block is compressed first.
// Synchronous active-low reset loads the initial chain and clears the byte count.
// ----------------------------------------------------------------------------
`include "md5_hash_engine_core_assert.svh"

module md5_hash_engine_core
    import md5he_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5he_in_if.sink    i_in,
    md5he_out_if.source o_out
);

    t_state      r_state, n_state;
    t_next       r_next,  n_next;
    logic [5:0]  r_rnd,   n_rnd;
    logic [63:0] r_cnt,   n_cnt;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_blk   [16];
    logic [31:0] n_blk   [16];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic        r_out_vld, n_out_vld;
    logic [63:0] r_dig_lo, n_dig_lo;
    logic [63:0] r_dig_hi, n_dig_hi;

    logic        in_rdy;
    logic        in_acc;
    logic        out_load;
    logic [63:0] cnt_inc;
    logic [63:0] bit_len;
    logic [31:0] t_sum;
    logic [5:0]  pos;

    assign in_acc  = i_in.valid && in_rdy;
    assign cnt_inc = r_cnt + 64'd1;
    assign bit_len = {r_cnt[60:0], 3'b000};
    assign pos     = r_cnt[5:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.has_byte && cnt_inc[5:0] == 6'd0) begin
                        n_state = S_ROUND;
                    end else if (i_in.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD:   n_state = S_ROUND;
            S_ZBLK:  n_state = S_ROUND;
            S_ROUND: begin
                if (r_rnd == C_LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                case (r_next)
                    NX_IDLE: n_state = S_IDLE;
                    NX_PAD:  n_state = S_PAD;
                    NX_ZBLK: n_state = S_ZBLK;
                    NX_OUT:  n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_rdy   = (r_state == S_IDLE);
        out_load = (r_state == S_OUT) && (!r_out_vld || o_out.ready);
    end

    assign i_in.ready      = in_rdy;
    assign o_out.valid     = r_out_vld;
    assign o_out.digest_lo = r_dig_lo;
    assign o_out.digest_hi = r_dig_hi;

    assign t_sum = r_a + md5_f(r_rnd[5:4], r_b, r_c, r_d) + md5_k(r_rnd) + r_blk[md5_g(r_rnd)];

    // datapath
    always_comb begin
        n_next    = r_next;
        n_rnd     = r_rnd;
        n_cnt     = r_cnt;
        n_chain   = r_chain;
        n_blk     = r_blk;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_out_vld = r_out_vld && !o_out.ready;
        n_dig_lo  = r_dig_lo;
        n_dig_hi  = r_dig_hi;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.has_byte) begin
                    n_blk[r_cnt[5:2]][{r_cnt[1:0], 3'b000} +: 8] = i_in.msg_byte;
                    n_cnt  = cnt_inc;
                    n_next = i_in.last ? NX_PAD : NX_IDLE;
                end
            end
            S_PAD: begin
                for (int w = 0; w < 16; w++) begin
                    for (int l = 0; l < 4; l++) begin
                        if (6'(w * 4 + l) == pos) begin
                            n_blk[w][l*8 +: 8] = C_PAD_BYTE;
                        end else if (6'(w * 4 + l) > pos) begin
                            n_blk[w][l*8 +: 8] = 8'h00;
                        end
                    end
                end
                if (pos >= C_LEN_POS) begin
                    n_next = NX_ZBLK;
                end else begin
                    n_blk[14] = bit_len[31:0];
                    n_blk[15] = bit_len[63:32];
                    n_next    = NX_OUT;
                end
            end
            S_ZBLK: begin
                for (int w = 0; w < 14; w++) begin
                    n_blk[w] = 32'h0;
                end
                n_blk[14] = bit_len[31:0];
                n_blk[15] = bit_len[63:32];
                n_next    = NX_OUT;
            end
            S_ROUND: begin
                n_a   = r_d;
                n_d   = r_c;
                n_c   = r_b;
                n_b   = r_b + rotl32(t_sum, md5_s(r_rnd));
                n_rnd = r_rnd + 6'd1;
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
            end
            S_OUT: begin
                if (out_load) begin
                    n_dig_lo  = {r_chain[1], r_chain[0]};
                    n_dig_hi  = {r_chain[3], r_chain[2]};
                    n_out_vld = 1'b1;
                    n_chain   = C_INIT;
                    n_cnt     = 64'd0;
                end
            end
            default: ;
        endcase

        // load working words at block start
        if (n_state == S_ROUND && r_state != S_ROUND) begin
            n_a   = n_chain[0];
            n_b   = n_chain[1];
            n_c   = n_chain[2];
            n_d   = n_chain[3];
            n_rnd = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next    <= NX_IDLE;
            r_rnd     <= 6'd0;
            r_cnt     <= 64'd0;
            r_chain   <= C_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next    <= n_next;
            r_rnd     <= n_rnd;
            r_cnt     <= n_cnt;
            r_chain   <= n_chain;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk    <= n_blk;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_d      <= n_d;
        r_dig_lo <= n_dig_lo;
        r_dig_hi <= n_dig_hi;
    end

    `MD5HE_ASSERT_NEXT(a_round_end, i_clk, i_rst_n,
        (r_state == S_ROUND && r_rnd == C_LAST_ROUND), (r_state == S_ADD),
        "round counter did not hand off to chain add")
    `MD5HE_ASSERT_IMPL(a_block_edge, i_clk, i_rst_n,
        (r_state == S_IDLE && n_state == S_ROUND), (n_cnt[5:0] == 6'd0),
        "compression started off a block boundary")
    `MD5HE_ASSERT_NEXT(a_reinit, i_clk, i_rst_n, out_load,
        (r_cnt == 64'd0 && r_chain[0] == C_INIT[0] && r_out_vld),
        "digest beat not followed by chain reinit")

endmodule
